@@ rtl/nesp_pkg.sv @@
// Shared widths, constants and the slot record of the note-on event scheduler.
package nesp_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 32;

  localparam int unsigned TempoW = 10;
  localparam int unsigned TimeW  = 24;
  localparam int unsigned RemW   = 27;
  localparam int unsigned DlyW   = 26;
  localparam int unsigned StepW  = 12;
  localparam int unsigned LenW   = 11;
  localparam int unsigned DivW   = 23;
  localparam int unsigned CntW   = 5;

  // Tempo * 256 / 75 equals (tempo * STEP_MUL) >> 16 exactly over the whole 10-bit tempo range.
  localparam int unsigned StepMulW   = 18;
  localparam int unsigned StepShift  = 16;
  localparam logic [StepMulW-1:0] STEP_MUL = 18'd223697;

  localparam logic [TempoW-1:0] TEMPO_RESET = 10'd120;
  localparam logic [6:0]        LEN_MUL     = 7'd120;
  localparam logic [LenW-1:0]   LEN_MIN     = 11'd1;
  localparam logic [LenW-1:0]   LEN_MAX     = 11'd1440;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic signed [RemW-1:0] remaining;
    logic signed [DlyW-1:0] delay;
    logic                   pending;
    logic [7:0]             track;
    logic [6:0]             note;
    logic [6:0]             vel;
    logic [TimeW-1:0]       dur;
  } slot_t;

endpackage

@@ rtl/note_on_event_scheduler.sv @@
// Top level of the note-on event scheduler: a pool of note timers kept in one slot memory.
// An add beat scans the slots one per cycle and stops at the first free one; an add with a negative note is dropped.
// A tick beat derives its step by a constant multiplication in the accepting cycle, then keeps
// busy high while it walks every slot, running the shared bit-serial divider once for every
// note-on it emits; the last note-on leaves in the first cycle after busy falls.
// Only one beat is in work at a time: a new beat is taken only in the idle state.
// Results leave as one-cycle strobes that the receiver cannot stall.
// Reset clears the control state and the per-slot valid bits at once; there is no sweep.
module note_on_event_scheduler #(
  parameter int unsigned SLOT_COUNT = nesp_pkg::SLOT_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [nesp_pkg::TempoW-1:0]  cfg_data_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         kind_i,
  input  logic [7:0]                   track_id_i,
  input  logic signed [7:0]            note_number_i,
  input  logic [6:0]                   velocity_i,
  input  logic [nesp_pkg::TimeW-1:0]   start_delay_i,
  input  logic [nesp_pkg::TimeW-1:0]   note_duration_i,
  output logic                         out_valid_o,
  output logic [7:0]                   out_track_o,
  output logic [6:0]                   out_note_o,
  output logic [6:0]                   out_velocity_o,
  output logic [nesp_pkg::LenW-1:0]    out_length_o,
  output logic                         last_o
);
  import nesp_pkg::*;

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IdxW-1:0] LAST_IDX = IdxW'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADD, ST_TICK, ST_LEN, ST_FIN
  } state_e;

  // The slot memory: one write port and one registered read port.
  slot_t mem_q [SLOT_COUNT];
  slot_t rdata_q;
  logic            mem_re, mem_we;
  logic [IdxW-1:0] mem_raddr;
  slot_t           mem_wdata;

  state_e state_q, state_d;
  logic [TempoW-1:0] tempo_q, tempo_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [DivW-1:0]   div_num_q, div_num_d;
  logic [TempoW-1:0] div_rem_q, div_rem_d, div_den_q, div_den_d;
  logic [CntW-1:0]   div_cnt_q, div_cnt_d;
  logic [7:0]        add_track_q, add_track_d;
  logic [6:0]        add_note_q, add_note_d, add_vel_q, add_vel_d;
  logic [TimeW-1:0]  add_dly_q, add_dly_d, add_dur_q, add_dur_d;
  logic              hold_v_q, hold_v_d;
  logic [7:0]        hold_track_q, hold_track_d;
  logic [6:0]        hold_note_q, hold_note_d, hold_vel_q, hold_vel_d;
  logic [LenW-1:0]   hold_len_q, hold_len_d;
  logic              out_v_q, out_v_d, last_q, last_d;
  logic [7:0]        out_track_q, out_track_d;
  logic [6:0]        out_note_q, out_note_d, out_vel_q, out_vel_d;
  logic [LenW-1:0]   out_len_q, out_len_d;

  slot_t             rd;
  slot_t             wr;
  logic [TempoW-1:0] eff_tempo;
  logic [TempoW+StepMulW-1:0] step_prod;
  logic [TempoW:0]   trial;
  logic              qbit;
  logic [DivW-1:0]   quot;
  logic              div_done, adv;
  logic [30:0]       len_prod;
  logic [LenW-1:0]   len_clamped;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // A slot never written reads as free with nothing pending.
  always_comb begin
    rd = rdata_q;
    if (!valid_q[idx_q]) begin
      rd = '0;
    end
  end

  assign eff_tempo = (tempo_q == '0) ? TempoW'(1) : tempo_q;

  // The tick step is a division by a constant, done as a multiplication by its reciprocal.
  assign step_prod = {{StepMulW{1'b0}}, eff_tempo} * {{TempoW{1'b0}}, STEP_MUL};

  // One restoring division step per cycle; the quotient shifts in where the dividend leaves.
  assign trial    = {div_rem_q, div_num_q[DivW-1]};
  assign qbit     = (trial >= {1'b0, div_den_q});
  assign quot     = {div_num_q[DivW-2:0], qbit};
  assign div_done = (div_cnt_q == CntW'(DivW - 1));
  assign len_prod = {7'b0, rd.dur} * {24'b0, LEN_MUL};

  always_comb begin
    if (quot == '0) begin
      len_clamped = LEN_MIN;
    end else if (quot > {12'b0, LEN_MAX}) begin
      len_clamped = LEN_MAX;
    end else begin
      len_clamped = quot[LenW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;  tempo_d = tempo_q;  idx_d = idx_q;  valid_d = valid_q;
    step_d = step_q;  div_num_d = div_num_q;  div_rem_d = div_rem_q;
    div_den_d = div_den_q;  div_cnt_d = div_cnt_q;
    add_track_d = add_track_q;  add_note_d = add_note_q;  add_vel_d = add_vel_q;
    add_dly_d = add_dly_q;  add_dur_d = add_dur_q;
    hold_v_d = hold_v_q;  hold_track_d = hold_track_q;  hold_note_d = hold_note_q;
    hold_vel_d = hold_vel_q;  hold_len_d = hold_len_q;
    out_v_d = 1'b0;  last_d = 1'b0;  out_track_d = out_track_q;  out_note_d = out_note_q;
    out_vel_d = out_vel_q;  out_len_d = out_len_q;
    mem_re = 1'b0;  mem_we = 1'b0;  mem_raddr = idx_q;  mem_wdata = rd;
    wr = rd;  adv = 1'b0;

    if (cfg_we_i) begin
      tempo_d = cfg_data_i;
    end

    // The divider runs whenever a division is under way.
    if (state_q == ST_LEN) begin
      div_rem_d = qbit ? TempoW'(trial - {1'b0, div_den_q}) : trial[TempoW-1:0];
      div_num_d = quot;
      div_cnt_d = div_cnt_q + CntW'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (kind_i == KIND_TICK) begin
            step_d    = step_prod[StepW+StepShift-1:StepShift];
            idx_d     = '0;
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_d   = ST_TICK;
          end else if (!note_number_i[7]) begin
            add_track_d = track_id_i;
            add_note_d  = note_number_i[6:0];
            add_vel_d   = velocity_i;
            add_dly_d   = start_delay_i;
            add_dur_d   = note_duration_i;
            idx_d       = '0;
            mem_re      = 1'b1;
            mem_raddr   = '0;
            state_d     = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        if (rd.remaining <= 0) begin
          wr.remaining = RemW'({1'b0, add_dly_q} + {1'b0, add_dur_q});
          wr.delay     = DlyW'(add_dly_q);
          wr.pending   = 1'b1;
          wr.track     = add_track_q;
          wr.note      = add_note_q;
          wr.vel       = add_vel_q;
          wr.dur       = add_dur_q;
          mem_we       = 1'b1;
          mem_wdata    = wr;
          valid_d[idx_q] = 1'b1;
          state_d      = ST_IDLE;
        end else if (idx_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end else begin
          idx_d     = idx_q + IdxW'(1);
          mem_re    = 1'b1;
          mem_raddr = idx_q + IdxW'(1);
        end
      end
      ST_TICK: begin
        adv = 1'b1;
        if (rd.remaining > 0) begin
          wr.remaining = rd.remaining - $signed({{(RemW-StepW){1'b0}}, step_q});
          if (rd.delay <= 0) begin
            if (rd.pending) begin
              wr.pending = 1'b0;
              div_num_d  = len_prod[30:8];
              div_rem_d  = '0;
              div_den_d  = eff_tempo;
              div_cnt_d  = '0;
              state_d    = ST_LEN;
              adv        = 1'b0;
            end
          end else begin
            wr.delay = rd.delay - $signed({{(DlyW-StepW){1'b0}}, step_q});
          end
          mem_we    = 1'b1;
          mem_wdata = wr;
        end
      end
      ST_LEN: begin
        if (div_done) begin
          // The note held back goes out now; it is known not to be the tick's last.
          if (hold_v_q) begin
            out_v_d     = 1'b1;
            out_track_d = hold_track_q;
            out_note_d  = hold_note_q;
            out_vel_d   = hold_vel_q;
            out_len_d   = hold_len_q;
          end
          hold_v_d     = 1'b1;
          hold_track_d = rd.track;
          hold_note_d  = rd.note;
          hold_vel_d   = rd.vel;
          hold_len_d   = len_clamped;
          adv          = 1'b1;
          state_d      = ST_TICK;
        end
      end
      ST_FIN: begin
        if (hold_v_q) begin
          out_v_d     = 1'b1;
          last_d      = 1'b1;
          out_track_d = hold_track_q;
          out_note_d  = hold_note_q;
          out_vel_d   = hold_vel_q;
          out_len_d   = hold_len_q;
        end
        hold_v_d = 1'b0;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (adv) begin
      if (idx_q == LAST_IDX) begin
        state_d = ST_FIN;
      end else begin
        idx_d     = idx_q + IdxW'(1);
        mem_re    = 1'b1;
        mem_raddr = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tempo_q  <= TEMPO_RESET;
      idx_q    <= '0;
      valid_q  <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      last_q   <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      state_q  <= state_d;
      tempo_q  <= tempo_d;
      idx_q    <= idx_d;
      valid_q  <= valid_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
      last_q   <= last_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q       <= step_d;
    div_num_q    <= div_num_d;
    div_rem_q    <= div_rem_d;
    div_den_q    <= div_den_d;
    add_track_q  <= add_track_d;
    add_note_q   <= add_note_d;
    add_vel_q    <= add_vel_d;
    add_dly_q    <= add_dly_d;
    add_dur_q    <= add_dur_d;
    hold_track_q <= hold_track_d;
    hold_note_q  <= hold_note_d;
    hold_vel_q   <= hold_vel_d;
    hold_len_q   <= hold_len_d;
    out_track_q  <= out_track_d;
    out_note_q   <= out_note_d;
    out_vel_q    <= out_vel_d;
    out_len_q    <= out_len_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign out_valid_o    = out_v_q;
  assign out_track_o    = out_track_q;
  assign out_note_o     = out_note_q;
  assign out_velocity_o = out_vel_q;
  assign out_length_o   = out_len_q;
  assign last_o         = last_q;

  // A tick beat always starts work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && kind_i == KIND_TICK) |=> busy_o)
    else $error("tick beat did not start a scan");

  // Every emitted length lies within the clamp range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_length_o >= LEN_MIN && out_length_o <= LEN_MAX))
    else $error("note length outside clamp range");

  // The last flag only comes with a result and closes the tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> (out_valid_o && !busy_o))
    else $error("last flag without a result or with the tick still running");

endmodule

@@ tb/tb_note_on_event_scheduler.sv @@
// Self-checking testbench of the note-on event scheduler: directed table, random beats, predictor.
`timescale 1ns / 100ps

module tb_note_on_event_scheduler;
  import nesp_pkg::*;

  localparam int unsigned NSLOT    = SLOT_COUNT_DEF;
  localparam int unsigned N_RANDOM = 280;
  localparam int unsigned SETTLE   = 900;     // outlasts the longest tick beat
  localparam longint      MAX_CYC  = 4000000;

  typedef struct packed {
    logic              kind;
    logic [7:0]        track;
    logic signed [7:0] note;
    logic [6:0]        vel;
    logic [TimeW-1:0]  dly;
    logic [TimeW-1:0]  dur;
  } beat_t;

  typedef struct packed {
    logic [7:0]      track;
    logic [6:0]      note;
    logic [6:0]      vel;
    logic [LenW-1:0] len;
    logic            last;
  } note_on_t;

  // One row of the directed table; a typed note-on is given only where it is obvious.
  typedef struct packed {
    beat_t    beat;
    logic     has_typed;
    note_on_t typed;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [TempoW-1:0]   cfg_data_i = '0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic                kind_i = 1'b0;
  logic [7:0]          track_id_i = '0;
  logic signed [7:0]   note_number_i = '0;
  logic [6:0]          velocity_i = '0;
  logic [TimeW-1:0]    start_delay_i = '0;
  logic [TimeW-1:0]    note_duration_i = '0;
  logic                out_valid_o;
  logic [7:0]          out_track_o;
  logic [6:0]          out_note_o;
  logic [6:0]          out_velocity_o;
  logic [LenW-1:0]     out_length_o;
  logic                last_o;

  note_on_event_scheduler i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .track_id_i     (track_id_i),
    .note_number_i  (note_number_i),
    .velocity_i     (velocity_i),
    .start_delay_i  (start_delay_i),
    .note_duration_i(note_duration_i),
    .out_valid_o    (out_valid_o),
    .out_track_o    (out_track_o),
    .out_note_o     (out_note_o),
    .out_velocity_o (out_velocity_o),
    .out_length_o   (out_length_o),
    .last_o         (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the timer pool. Times are held signed, exactly as the block keeps them.
  logic [TempoW-1:0] tempo_q;
  int                pool_delay  [NSLOT];
  int                pool_remain [NSLOT];
  bit                pool_pending[NSLOT];
  logic [7:0]        pool_track  [NSLOT];
  logic [6:0]        pool_note   [NSLOT];
  logic [6:0]        pool_vel    [NSLOT];
  logic [TimeW-1:0]  pool_dur    [NSLOT];

  note_on_t fired_q[$];     // note-ons that the latest tick beat should cause
  note_on_t awaited_q[$];   // note-ons still to be seen on the result ports
  int       n_errors   = 0;
  int       n_seen     = 0;
  int       n_ticks    = 0;
  int       n_adds     = 0;
  longint   cycle_cnt  = 0;

  function automatic int unsigned live_tempo();
    return (tempo_q == '0) ? 1 : int'(tempo_q);
  endfunction

  function automatic int step_ticks();
    return int'((live_tempo() * 256) / 75);
  endfunction

  // Sequencer length of a note: duration scaled by tempo, then saturated.
  function automatic logic [LenW-1:0] length_of(logic [TimeW-1:0] dur);
    longint unsigned q;
    q = (longint'(dur) * 120) / (longint'(256) * live_tempo());
    if (q < 1) return LEN_MIN;
    if (q > 1440) return LEN_MAX;
    return q[LenW-1:0];
  endfunction

  // Updates the shadow pool for one accepted beat and leaves any note-ons in fired_q.
  task automatic advance_pool(input beat_t b);
    int step;
    note_on_t r;
    fired_q.delete();
    if (b.kind == KIND_ADD) begin
      n_adds++;
      if (b.note[7]) return;     // negative note: the add is dropped
      for (int i = 0; i < NSLOT; i++) begin
        if (pool_remain[i] <= 0) begin
          pool_track[i]   = b.track;
          pool_note[i]    = b.note[6:0];
          pool_vel[i]     = b.vel;
          pool_dur[i]     = b.dur;
          pool_delay[i]   = int'(b.dly);
          pool_remain[i]  = int'(b.dly) + int'(b.dur);
          pool_pending[i] = 1'b1;
          return;
        end
      end
      return;                    // pool full
    end
    n_ticks++;
    step = step_ticks();
    for (int i = 0; i < NSLOT; i++) begin
      if (pool_remain[i] <= 0) continue;
      pool_remain[i] -= step;
      if (pool_delay[i] <= 0) begin
        if (pool_pending[i]) begin
          r.track = pool_track[i];
          r.note  = pool_note[i];
          r.vel   = pool_vel[i];
          r.len   = length_of(pool_dur[i]);
          r.last  = 1'b0;
          fired_q.push_back(r);
          pool_pending[i] = 1'b0;
        end
      end else begin
        pool_delay[i] -= step;
      end
    end
    if (fired_q.size() > 0) fired_q[fired_q.size()-1].last = 1'b1;
  endtask

  // Presents one beat from the current edge and returns at the edge where it is taken.
  // Start stays high on return, so a following beat can go out without a gap.
  task automatic send_beat(input beat_t b);
    start_i         <= 1'b1;
    kind_i          <= b.kind;
    track_id_i      <= b.track;
    note_number_i   <= b.note;
    velocity_i      <= b.vel;
    start_delay_i   <= b.dly;
    note_duration_i <= b.dur;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Random idling on the sending side; quiet is set for the stretch without gaps.
  task automatic maybe_idle(input bit quiet);
    int gap;
    if (quiet || $urandom_range(99) >= 10) return;
    gap = $urandom_range(1, 20);
    start_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  // Waits until every note-on has come and the block has finished any silent work,
  // then writes the tempo register.
  task automatic write_tempo(input logic [TempoW-1:0] t);
    start_i <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= t;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tempo_q = t;
  endtask

  function automatic row_t mk_row(logic kind, logic [7:0] trk, logic signed [7:0] note,
                                  logic [6:0] vel, logic [TimeW-1:0] dly,
                                  logic [TimeW-1:0] dur, logic has_typed,
                                  note_on_t typed);
    row_t r;
    r.beat      = '{kind, trk, note, vel, dly, dur};
    r.has_typed = has_typed;
    r.typed     = typed;
    return r;
  endfunction

  // Random beat whose times are a few tick steps long at the present tempo, so that
  // slots fill, fire and free again rather than sit idle for the whole run.
  function automatic beat_t random_beat();
    beat_t b;
    int    step;
    step    = step_ticks();
    b.kind  = ($urandom_range(99) < 45) ? KIND_TICK : KIND_ADD;
    b.track = 8'($urandom());
    b.vel   = 7'($urandom());
    if ($urandom_range(99) < 10) b.note = -8'sd1 - 8'($urandom_range(127));
    else b.note = 8'($urandom_range(127));
    b.dly   = 24'($urandom_range(0, step * 4));
    b.dur   = 24'($urandom_range(0, step * 8));
    if ($urandom_range(99) < 8) b.dly = '0;
    if ($urandom_range(99) < 5) b.dur = '0;
    return b;
  endfunction

  // Every result beat is compared with the oldest outstanding note-on.
  always @(posedge clk_i) begin
    note_on_t x;
    if (rst_ni && out_valid_o) begin
      n_seen++;
      if (awaited_q.size() == 0) begin
        $error("note-on beat with nothing outstanding: track %0d note %0d",
               out_track_o, out_note_o);
        n_errors++;
      end else begin
        x = awaited_q.pop_front();
        if (out_track_o !== x.track) begin
          $error("out_track expected %0d got %0d", x.track, out_track_o); n_errors++;
        end
        if (out_note_o !== x.note) begin
          $error("out_note expected %0d got %0d", x.note, out_note_o); n_errors++;
        end
        if (out_velocity_o !== x.vel) begin
          $error("out_velocity expected %0d got %0d", x.vel, out_velocity_o); n_errors++;
        end
        if (out_length_o !== x.len) begin
          $error("out_length expected %0d got %0d", x.len, out_length_o); n_errors++;
        end
        if (last_o !== x.last) begin
          $error("last expected %0d got %0d", x.last, last_o); n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYC) begin
      $display("timeout with %0d note-ons outstanding", awaited_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    row_t     table_q[$];
    note_on_t none;
    int       n_phase;
    logic [TempoW-1:0] phase_tempo[6];
    none = '0;
    tempo_q = TEMPO_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      pool_delay[i] = 0; pool_remain[i] = 0; pool_pending[i] = 1'b0;
      pool_track[i] = '0; pool_note[i] = '0; pool_vel[i] = '0; pool_dur[i] = '0;
    end

    // Directed table at the reset tempo of 120, where one step is 409 in 16.8 ticks.
    // Largest duration, zero delay: fires at once and saturates the length to its top.
    table_q.push_back(mk_row(KIND_ADD, 8'd0, 8'sd127, 7'd127, 24'd0, 24'hFFFFFF, 1'b0, none));
    table_q.push_back(mk_row(KIND_TICK, 8'hFF, -8'sd1, 7'h7F, 24'hFFFFFF, 24'hFFFFFF, 1'b1,
                             '{8'd0, 7'd127, 7'd127, 11'd1440, 1'b1}));
    // Negative notes are dropped, so the next tick has nothing to fire.
    table_q.push_back(mk_row(KIND_ADD, 8'd9, -8'sd1, 7'd5, 24'd0, 24'd512, 1'b0, none));
    table_q.push_back(mk_row(KIND_ADD, 8'd9, -8'sd128, 7'd5, 24'd0, 24'd512, 1'b0, none));
    table_q.push_back(mk_row(KIND_TICK, 8'd0, 8'sd0, 7'd0, 24'd0, 24'd0, 1'b0, none));
    // Smallest duration: the length clamps up to one.
    table_q.push_back(mk_row(KIND_ADD, 8'd255, 8'sd0, 7'd0, 24'd0, 24'd1, 1'b0, none));
    table_q.push_back(mk_row(KIND_TICK, 8'd3, 8'sd3, 7'd3, 24'd3, 24'd3, 1'b1,
                             '{8'd255, 7'd0, 7'd0, 11'd1, 1'b1}));
    // Zero delay with zero duration stays free; zero duration after a delay never fires.
    table_q.push_back(mk_row(KIND_ADD, 8'd1, 8'sd1, 7'd1, 24'd0, 24'd0, 1'b0, none));
    table_q.push_back(mk_row(KIND_ADD, 8'd2, 8'sd2, 7'd2, 24'd409, 24'd0, 1'b0, none));
    table_q.push_back(mk_row(KIND_ADD, 8'd3, 8'sd64, 7'd64, 24'd800, 24'd3000, 1'b0, none));
    table_q.push_back(mk_row(KIND_TICK, 8'd0, 8'sd0, 7'd0, 24'd0, 24'd0, 1'b0, none));
    table_q.push_back(mk_row(KIND_TICK, 8'd0, 8'sd0, 7'd0, 24'd0, 24'd0, 1'b0, none));
    table_q.push_back(mk_row(KIND_TICK, 8'd0, 8'sd0, 7'd0, 24'd0, 24'd0, 1'b0, none));
    // Several note-ons from one tick, with last only on the final one.
    for (int i = 0; i < 4; i++)
      table_q.push_back(mk_row(KIND_ADD, 8'(40 + i), 8'(20 + i), 7'(90 + i), 24'd0,
                               24'(1000 * (i + 1)), 1'b0, none));
    table_q.push_back(mk_row(KIND_TICK, 8'd0, 8'sd0, 7'd0, 24'd0, 24'd0, 1'b0, none));
    // Largest delay: all delay bits high; this slot stays busy for the rest of the run.
    table_q.push_back(mk_row(KIND_ADD, 8'h55, 8'sd85, 7'h2A, 24'hFFFFFF, 24'd0, 1'b0, none));
    table_q.push_back(mk_row(KIND_TICK, 8'd0, 8'sd0, 7'd0, 24'd0, 24'd0, 1'b0, none));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (table_q[k]) begin
      send_beat(table_q[k].beat);
      advance_pool(table_q[k].beat);
      if (table_q[k].has_typed) awaited_q.push_back(table_q[k].typed);
      else foreach (fired_q[j]) awaited_q.push_back(fired_q[j]);
      maybe_idle(1'b0);
    end

    // Random part in phases, each at its own tempo; the extremes and zero come first.
    phase_tempo = '{10'd1, 10'd960, 10'd0, 10'd1023, 10'd120, 10'd480};
    n_phase = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      beat_t b;
      if (n % 35 == 0) begin
        write_tempo(n_phase < 6 ? phase_tempo[n_phase] : 10'($urandom_range(1, 960)));
        n_phase++;
      end
      b = random_beat();
      send_beat(b);
      advance_pool(b);
      foreach (fired_q[j]) awaited_q.push_back(fired_q[j]);
      maybe_idle(n >= 100 && n < 180);
    end
    start_i <= 1'b0;

    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("%0d add and %0d tick beats over %0d tempo settings, %0d note-ons checked",
             n_adds, n_ticks, n_phase + 1, n_seen);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
